// ----- rtl/pctd_pkg.sv -----
// ----------------------------------------------------------------------------
// pctd_pkg - shared types and constants of the prefix code table decoder
// Sizes, codes, beat structs and the control struct of the cell chain.
// ----------------------------------------------------------------------------
package pctd_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int MAX_CODE_BITS = 16;

   localparam int KIND_W   = 2;
   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 16;
   localparam int LENGTH_W = 5;
   localparam int STATUS_W = 2;

   localparam int PREFIX_W = MAX_CODE_BITS;
   localparam int PLEN_W   = $clog2(MAX_CODE_BITS + 1);
   localparam int COUNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int INDEX_W  = $clog2(TABLE_ENTRIES);

   typedef logic [PREFIX_W-1:0] prefix_type;
   typedef logic [PLEN_W-1:0]   plen_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [INDEX_W-1:0]  index_type;

   localparam count_type FULL_COUNT = count_type'(TABLE_ENTRIES);
   localparam plen_type  PLEN_MAX   = plen_type'(MAX_CODE_BITS);

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD  = 2'd0,
      KIND_BIT   = 2'd1,
      KIND_END   = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_SYMBOL   = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_LEFTOVER = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SYMBOL_W-1:0] entry_symbol;
      logic [CODE_W-1:0]   entry_code;
      logic [LENGTH_W-1:0] entry_length;
      logic                code_bit;
   } req_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] out_symbol;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic [CODE_W-1:0]   code;
      logic [LENGTH_W-1:0] length;
   } entry_type;

   typedef struct packed {
      logic                found;
      logic [SYMBOL_W-1:0] symbol;
   } token_type;

   typedef struct packed {
      logic shift;
      logic init;
      logic chain;
   } cell_ctl_type;

   function automatic prefix_type code_to_prefix(logic [CODE_W-1:0] code);
      return prefix_type'(code);
   endfunction

   function automatic logic [LENGTH_W-1:0] plen_to_length(plen_type plen);
      return LENGTH_W'(plen);
   endfunction

   function automatic count_type index_to_count(int index);
      return count_type'(index);
   endfunction

endpackage

// ----- rtl/prefix_code_table_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// prefix_code_table_decoder_unit - prefix code decoder with loadable codebook
//
//   port group   dir   beat contents
//   req_*        in    kind, entry_symbol, entry_code, entry_length, code_bit
//   rsp_*        out   out_symbol, status
//
// load, clear and end beats are handled in the idle state. a code bit that
// reaches the table starts a search: the hit token walks the cell row one cell
// per cycle toward cell 0. a bit into an empty table or a prefix overflow needs
// no search. reset empties the table and the prefix, no clearing pass. a held
// result beat stalls beats that would give a result at once and holds a finished search.
// ----------------------------------------------------------------------------
module prefix_code_table_decoder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pctd_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pctd_pkg::rsp_type  rsp_data
);

   pctd_pkg::state_type    state_ff, state_in;
   pctd_pkg::index_type    step_ff, step_in;
   pctd_pkg::count_type    entry_count_ff, entry_count_in;
   pctd_pkg::prefix_type   prefix_bits_ff, prefix_bits_in;
   pctd_pkg::plen_type     prefix_length_ff, prefix_length_in;
   logic                   rsp_valid_ff;
   pctd_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                   rsp_load;

   pctd_pkg::cell_ctl_type cell_ctl;
   pctd_pkg::entry_type    new_entry;
   pctd_pkg::entry_type    entries [pctd_pkg::TABLE_ENTRIES];
   pctd_pkg::token_type    tokens  [pctd_pkg::TABLE_ENTRIES];

   logic                   req_accept;
   logic                   out_free;
   logic                   table_full;
   logic                   prefix_full;
   logic                   result_now;
   pctd_pkg::index_type    last_step;

   assign req_accept  = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign table_full  = (entry_count_ff == pctd_pkg::FULL_COUNT);
   assign prefix_full = (prefix_length_ff == pctd_pkg::PLEN_MAX);
   assign last_step   = pctd_pkg::index_type'(entry_count_ff - 1'b1);

   assign new_entry.symbol = req_data.entry_symbol;
   assign new_entry.code   = req_data.entry_code;
   assign new_entry.length = req_data.entry_length;

   always_comb begin
      unique case (req_data.kind)
         pctd_pkg::KIND_LOAD:  result_now = table_full;
         pctd_pkg::KIND_BIT:   result_now = prefix_full;
         pctd_pkg::KIND_END:   result_now = (prefix_length_ff != '0);
         pctd_pkg::KIND_CLEAR: result_now = 1'b0;
         default:              result_now = 1'b0;
      endcase
   end

   assign req_stall = (state_ff != pctd_pkg::ST_IDLE) || (result_now && !out_free);

   // cell row
   for (genvar i = 0; i < pctd_pkg::TABLE_ENTRIES; i++) begin : g_cell
      pctd_pkg::entry_type entry_left;
      pctd_pkg::token_type token_right;
      logic                entry_valid;

      if (i == 0) begin : g_head
         assign entry_left = new_entry;
      end else begin : g_body
         assign entry_left = entries[i-1];
      end

      if (i == pctd_pkg::TABLE_ENTRIES - 1) begin : g_tail
         assign token_right = '0;
      end else begin : g_link
         assign token_right = tokens[i+1];
      end

      assign entry_valid = (pctd_pkg::index_to_count(i) < entry_count_ff);

      pctd_cell u_cell (
         .clock         (clock),
         .ctl           (cell_ctl),
         .entry_valid   (entry_valid),
         .entry_left    (entry_left),
         .entry_out     (entries[i]),
         .prefix        (prefix_bits_ff),
         .prefix_length (prefix_length_ff),
         .token_right   (token_right),
         .token_out     (tokens[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pctd_pkg::ST_IDLE: begin
            if (req_accept && (req_data.kind == pctd_pkg::KIND_BIT) && !prefix_full &&
                (entry_count_ff != '0)) begin
               state_in = pctd_pkg::ST_SEARCH;
            end
         end
         pctd_pkg::ST_SEARCH: begin
            if (step_ff == last_step) begin
               state_in = pctd_pkg::ST_DONE;
            end
         end
         pctd_pkg::ST_DONE: begin
            if (!tokens[0].found || out_free) begin
               state_in = pctd_pkg::ST_IDLE;
            end
         end
         default: state_in = pctd_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      cell_ctl         = '0;
      step_in          = step_ff;
      entry_count_in   = entry_count_ff;
      prefix_bits_in   = prefix_bits_ff;
      prefix_length_in = prefix_length_ff;
      rsp_load         = 1'b0;
      rsp_data_in      = '0;
      unique case (state_ff)
         pctd_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.kind)
                  pctd_pkg::KIND_LOAD: begin
                     if (table_full) begin
                        rsp_load           = 1'b1;
                        rsp_data_in.status = pctd_pkg::STATUS_FULL;
                     end else begin
                        cell_ctl.shift = 1'b1;
                        entry_count_in = pctd_pkg::count_type'(entry_count_ff + 1'b1);
                     end
                  end
                  pctd_pkg::KIND_BIT: begin
                     if (prefix_full) begin
                        prefix_bits_in     = '0;
                        prefix_length_in   = '0;
                        rsp_load           = 1'b1;
                        rsp_data_in.status = pctd_pkg::STATUS_OVERFLOW;
                     end else begin
                        prefix_bits_in   = {prefix_bits_ff[pctd_pkg::PREFIX_W-2:0],
                                            req_data.code_bit};
                        prefix_length_in = pctd_pkg::plen_type'(prefix_length_ff + 1'b1);
                        step_in          = '0;
                     end
                  end
                  pctd_pkg::KIND_END: begin
                     if (prefix_length_ff != '0) begin
                        prefix_bits_in     = '0;
                        prefix_length_in   = '0;
                        rsp_load           = 1'b1;
                        rsp_data_in.status = pctd_pkg::STATUS_LEFTOVER;
                     end
                  end
                  pctd_pkg::KIND_CLEAR: begin
                     entry_count_in = '0;
                  end
                  default: begin
                     entry_count_in = entry_count_ff;
                  end
               endcase
            end
         end
         pctd_pkg::ST_SEARCH: begin
            cell_ctl.init  = (step_ff == '0);
            cell_ctl.chain = (step_ff != '0);
            step_in        = pctd_pkg::index_type'(step_ff + 1'b1);
         end
         pctd_pkg::ST_DONE: begin
            if (tokens[0].found && out_free) begin
               prefix_bits_in         = '0;
               prefix_length_in       = '0;
               rsp_load               = 1'b1;
               rsp_data_in.out_symbol = tokens[0].symbol;
               rsp_data_in.status     = pctd_pkg::STATUS_SYMBOL;
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= pctd_pkg::ST_IDLE;
         step_ff          <= '0;
         entry_count_ff   <= '0;
         prefix_bits_ff   <= '0;
         prefix_length_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         entry_count_ff   <= entry_count_in;
         prefix_bits_ff   <= prefix_bits_in;
         prefix_length_ff <= prefix_length_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == pctd_pkg::ST_IDLE))
      else $error("beat accepted while a search is running");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= pctd_pkg::FULL_COUNT)
      else $error("entry count past table size");

   a_prefix_bound: assert property (@(posedge clock) disable iff (reset)
      prefix_length_ff <= pctd_pkg::PLEN_MAX)
      else $error("prefix longer than longest code");

   a_search_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pctd_pkg::ST_SEARCH) |-> (entry_count_ff != '0))
      else $error("search over an empty table");

   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written over a held beat");
`endif

endmodule

// ----- rtl/pctd_cell.sv -----
// ----------------------------------------------------------------------------
// pctd_cell - one codebook cell of the decoder chain
// Holds one entry, shifts it on to the next cell on a load, compares it with
// the prefix and hands the oldest hit seen so far toward the head of the row.
// ----------------------------------------------------------------------------
module pctd_cell (
   input  logic                      clock,
   input  pctd_pkg::cell_ctl_type    ctl,
   input  logic                      entry_valid,
   input  pctd_pkg::entry_type       entry_left,
   output pctd_pkg::entry_type       entry_out,
   input  pctd_pkg::prefix_type      prefix,
   input  pctd_pkg::plen_type        prefix_length,
   input  pctd_pkg::token_type       token_right,
   output pctd_pkg::token_type       token_out
);

   pctd_pkg::entry_type  entry_ff;
   pctd_pkg::token_type  token_ff;
   pctd_pkg::token_type  token_in;
   pctd_pkg::token_type  own_token;
   pctd_pkg::prefix_type code_ext;
   logic                 code_equal;

   always_comb begin
      code_ext   = pctd_pkg::code_to_prefix(entry_ff.code);
      code_equal = 1'b1;
      for (int j = 0; j < pctd_pkg::PREFIX_W; j++) begin
         if ((j < int'(prefix_length)) && (code_ext[j] != prefix[j])) begin
            code_equal = 1'b0;
         end
      end
      own_token.found  = entry_valid && code_equal &&
                         (entry_ff.length == pctd_pkg::plen_to_length(prefix_length));
      own_token.symbol = entry_ff.symbol;
   end

   // older entries sit further right, so a hit from the right wins
   always_comb begin
      if (ctl.init || !token_right.found) begin
         token_in = own_token;
      end else begin
         token_in = token_right;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         entry_ff <= entry_left;
      end
      if (ctl.init || ctl.chain) begin
         token_ff <= token_in;
      end
   end

   assign entry_out = entry_ff;
   assign token_out = token_ff;

endmodule
